// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion helpers shared by the pixel engine modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define MPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// implication form of the above
`define MPE_ASSERT_IMPL(lbl, ante, cons, msg) \
  `MPE_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/mpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mpe_pkg
// types, fixed-point constants and saturation helper of the pixel engine
// ----------------------------------------------------------------------------
package mpe_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned COUNT_W   = 10;
  localparam int unsigned INTENS_W  = 8;
  localparam int unsigned Q_W       = 32;
  localparam int unsigned SAT_W     = 48;
  localparam int unsigned SPAN_W    = 30;
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned INTENS_SCALE = 255;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [CFG_W-1:0]    grid_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [INTENS_W-1:0] intens_t;
  typedef logic signed [Q_W-1:0] q_t;

  typedef struct packed {
    q_t re;
    q_t im;
  } cpoint_t;

  localparam grid_t GRID_RESET = 13'd1024;
  localparam grid_t GRID_ONE   = 13'd1;

  // Q4.28 window of the set
  localparam q_t                RE_MIN  = -32'sd536870912;
  localparam logic [SPAN_W-1:0] RE_SPAN = 30'd663035576;
  localparam q_t                IM_MIN  = -32'sd300647711;
  localparam logic [SPAN_W-1:0] IM_SPAN = 30'd601295421;

  localparam logic signed [SAT_W-1:0] SAT_HI     = 48'sh0000_7fff_ffff;
  localparam logic signed [SAT_W-1:0] SAT_LO     = 48'shffff_8000_0000;
  localparam logic signed [SAT_W-1:0] ESC_LIMIT  = 48'sd1073741824;
  localparam q_t                      Q_MAX_V    = 32'sh7fff_ffff;
  localparam q_t                      Q_MIN_V    = 32'sh8000_0000;

  function automatic q_t sat_q(input logic signed [SAT_W-1:0] v);
    q_t r;
    if (v > SAT_HI) begin
      r = Q_MAX_V;
    end else if (v < SAT_LO) begin
      r = Q_MIN_V;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/mpe_if.sv =====
// ----------------------------------------------------------------------------
// mpe_if
// valid/ready channels for pixel coordinates and escape-time results
// ----------------------------------------------------------------------------
interface mpe_pix_if;
  import mpe_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pixel_row;
  coord_t pixel_column;

  modport source(output valid, output pixel_row, output pixel_column, input ready);
  modport sink(input valid, input pixel_row, input pixel_column, output ready);
endinterface

interface mpe_res_if;
  import mpe_pkg::*;

  logic    valid;
  logic    ready;
  count_t  iteration_count;
  intens_t intensity;

  modport source(output valid, output iteration_count, output intensity, input ready);
  modport sink(input valid, input iteration_count, input intensity, output ready);
endinterface

// ===== rtl/mandelbrot_pixel_engine.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_pixel_engine
// escape-time pixel engine: maps a grid coordinate to c and counts the
// iterations of z = z*z + c until |z| > 2 or the limit is reached
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  pix_i     in   valid/ready        pixel_row, pixel_column
//  res_o     out  valid/ready        iteration_count, intensity
//  cfg       in   cfg_we_i           cfg_wdata_i (grid size)
//
//  mapping is a multiply followed by the bit-serial divide by the grid size;
//  the iteration stage runs the multiply-then-update loop once per iteration
//  until escape or the limit. the two stages overlap through a two-entry queue;
//  a stalled result holds the iteration stage, and the mapping stage too once
//  the queue is full. reset is asynchronous, active low, grid size 1024.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_engine #(
  parameter int unsigned MAX_ITERATIONS = 1000,
  parameter int unsigned COORD_BITS     = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  mpe_pkg::grid_t cfg_wdata_i,
  mpe_pix_if.sink        pix_i,
  mpe_res_if.source      res_o
);
  import mpe_pkg::*;

  grid_t   grid_q;
  cpoint_t f_pt, b_pt;
  logic    f_valid, f_ready, b_valid, b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      grid_q <= cfg_wdata_i;
    end
  end

  mpe_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grid_i     (grid_q),
    .pix_i      (pix_i),
    .pt_o       (f_pt),
    .pt_valid_o (f_valid),
    .pt_ready_i (f_ready)
  );

  mpe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (f_pt),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   (b_pt),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready)
  );

  mpe_back #(
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt_i       (b_pt),
    .pt_valid_i (b_valid),
    .pt_ready_o (b_ready),
    .res_o      (res_o)
  );

endmodule

// ===== rtl/mpe_front.sv =====
// ----------------------------------------------------------------------------
// mpe_front
// takes a pixel transaction and maps row and column to c by multiply and a
// bit-serial restoring divide by the grid size
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpe_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mpe_pkg::grid_t   grid_i,
  mpe_pix_if.sink          pix_i,
  output mpe_pkg::cpoint_t pt_o,
  output logic             pt_valid_o,
  input  logic             pt_ready_i
);
  import mpe_pkg::*;

  localparam int unsigned CW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int unsigned QW    = CW + SPAN_W;
  localparam int unsigned CNT_W = $clog2(QW + 1);
  localparam int unsigned REM_W = CFG_W + 1;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} fstate_e;

  fstate_e            state_q;
  logic [CW-1:0]      row_q, col_q;
  grid_t              div_q;
  logic [QW-1:0]      re_q, im_q;
  logic [REM_W-1:0]   re_rem_q, im_rem_q;
  logic [CNT_W-1:0]   step_q;

  logic signed [SAT_W-1:0] re_sum, im_sum;

  // one quotient bit per call, quotient shifts in where the dividend leaves
  function automatic logic [REM_W+QW-1:0] div_step(input logic [REM_W-1:0] rem,
                                                  input logic [QW-1:0] quo,
                                                  input grid_t d);
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] dx;
    logic [REM_W+QW-1:0] res;
    r  = {rem[REM_W-2:0], quo[QW-1]};
    dx = {1'b0, d};
    if (r >= dx) begin
      res = {r - dx, quo[QW-2:0], 1'b1};
    end else begin
      res = {r, quo[QW-2:0], 1'b0};
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      row_q    <= '0;
      col_q    <= '0;
      div_q    <= GRID_ONE;
      re_q     <= '0;
      im_q     <= '0;
      re_rem_q <= '0;
      im_rem_q <= '0;
      step_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (pix_i.valid) begin
            row_q   <= pix_i.pixel_row[CW-1:0];
            col_q   <= pix_i.pixel_column[CW-1:0];
            div_q   <= (grid_i == '0) ? GRID_ONE : grid_i;
            state_q <= F_MUL;
          end
        end
        F_MUL: begin
          re_q     <= {{SPAN_W{1'b0}}, col_q} * {{CW{1'b0}}, RE_SPAN};
          im_q     <= {{SPAN_W{1'b0}}, row_q} * {{CW{1'b0}}, IM_SPAN};
          re_rem_q <= '0;
          im_rem_q <= '0;
          step_q   <= '0;
          state_q  <= F_DIV;
        end
        F_DIV: begin
          {re_rem_q, re_q} <= div_step(re_rem_q, re_q, div_q);
          {im_rem_q, im_q} <= div_step(im_rem_q, im_q, div_q);
          step_q <= step_q + 1'b1;
          if (step_q == CNT_W'(QW - 1)) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (pt_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_comb begin
    re_sum = {{(SAT_W-Q_W){RE_MIN[Q_W-1]}}, RE_MIN} + {{(SAT_W-QW){1'b0}}, re_q};
    im_sum = {{(SAT_W-Q_W){IM_MIN[Q_W-1]}}, IM_MIN} + {{(SAT_W-QW){1'b0}}, im_q};
    pt_o.re = sat_q(re_sum);
    pt_o.im = sat_q(im_sum);
  end

  assign pix_i.ready = (state_q == F_IDLE);
  assign pt_valid_o  = (state_q == F_PUSH);

  `MPE_ASSERT_IMPL(a_front_step, state_q == F_DIV, step_q < CNT_W'(QW), "divide ran past its last bit")
  `MPE_ASSERT_IMPL(a_front_take, pix_i.valid && pix_i.ready, ##1 (state_q == F_MUL), "accepted pixel not mapped")

endmodule

// ===== rtl/mpe_queue.sv =====
// ----------------------------------------------------------------------------
// mpe_queue
// two-entry queue of mapped points between the mapping and iteration stages
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpe_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mpe_pkg::cpoint_t push_data_i,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  output mpe_pkg::cpoint_t pop_data_o,
  output logic             pop_valid_o,
  input  logic             pop_ready_i
);
  import mpe_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cpoint_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `MPE_ASSERT(a_queue_fill, cnt_q <= CNT_W'(DEPTH), "queue fill above depth")

endmodule

// ===== rtl/mpe_back.sv =====
// ----------------------------------------------------------------------------
// mpe_back
// escape-time iteration of z = z*z + c, a multiply state then an update
// state per step, with a running intensity kept as quotient and remainder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpe_back #(
  parameter int unsigned MAX_ITERATIONS = 1000
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mpe_pkg::cpoint_t pt_i,
  input  logic             pt_valid_i,
  output logic             pt_ready_o,
  mpe_res_if.source        res_o
);
  import mpe_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_ITERATIONS + 1);
  localparam int unsigned ACC_W  = $clog2(2 * MAX_ITERATIONS);
  localparam int unsigned Q_STEP = INTENS_SCALE / MAX_ITERATIONS;
  localparam int unsigned R_STEP = INTENS_SCALE % MAX_ITERATIONS;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_UPD, B_HOLD} bstate_e;

  bstate_e               state_q;
  cpoint_t               c_q;
  q_t                    zre_q, zim_q;
  logic signed [63:0]    prr_q, pii_q, pri_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [ACC_W-1:0]      rem_q;
  intens_t               lvl_q;
  logic                  res_valid_q;
  count_t                res_cnt_q;
  intens_t               res_int_q;

  logic signed [SAT_W-1:0] re2, im2, dbl_ri, cre_x, cim_x;
  logic                    done;
  logic                    res_load;
  logic                    pt_take;
  q_t                      nre, nim;
  logic [ACC_W-1:0]        rem_sum;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  always_comb begin
    re2      = SAT_W'(prr_q >>> FRAC_BITS);
    im2      = SAT_W'(pii_q >>> FRAC_BITS);
    dbl_ri   = SAT_W'(pri_q >>> (FRAC_BITS - 1));
    cre_x    = {{(SAT_W-Q_W){c_q.re[Q_W-1]}}, c_q.re};
    cim_x    = {{(SAT_W-Q_W){c_q.im[Q_W-1]}}, c_q.im};
    done     = ((re2 + im2) > ESC_LIMIT) || (cnt_q >= CNT_W'(MAX_ITERATIONS));
    nre      = sat_q(re2 - im2 + cre_x);
    nim      = sat_q(dbl_ri + cim_x);
    rem_sum  = rem_q + ACC_W'(R_STEP);
    cnt_ext  = {{COUNT_W{1'b0}}, cnt_q};
    res_load = (state_q == B_HOLD) && (!res_valid_q || res_o.ready);
    pt_take  = pt_valid_i && pt_ready_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      c_q         <= '0;
      zre_q       <= '0;
      zim_q       <= '0;
      prr_q       <= '0;
      pii_q       <= '0;
      pri_q       <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      lvl_q       <= '0;
      res_valid_q <= 1'b0;
      res_cnt_q   <= '0;
      res_int_q   <= '0;
    end else begin
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pt_valid_i) begin
            c_q     <= pt_i;
            zre_q   <= '0;
            zim_q   <= '0;
            cnt_q   <= '0;
            rem_q   <= '0;
            lvl_q   <= '0;
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          prr_q   <= zre_q * zre_q;
          pii_q   <= zim_q * zim_q;
          pri_q   <= zre_q * zim_q;
          state_q <= B_UPD;
        end
        B_UPD: begin
          if (done) begin
            state_q <= B_HOLD;
          end else begin
            zre_q <= nre;
            zim_q <= nim;
            cnt_q <= cnt_q + 1'b1;
            // 255/max per step, carried remainder bumps the level
            if (rem_sum >= ACC_W'(MAX_ITERATIONS)) begin
              rem_q <= rem_sum - ACC_W'(MAX_ITERATIONS);
              lvl_q <= lvl_q + INTENS_W'(Q_STEP) + 1'b1;
            end else begin
              rem_q <= rem_sum;
              lvl_q <= lvl_q + INTENS_W'(Q_STEP);
            end
            state_q <= B_MUL;
          end
        end
        B_HOLD: begin
          if (res_load) begin
            res_cnt_q   <= cnt_ext[COUNT_W-1:0];
            res_int_q   <= lvl_q;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign pt_ready_o            = (state_q == B_IDLE);
  assign res_o.valid           = res_valid_q;
  assign res_o.iteration_count = res_cnt_q;
  assign res_o.intensity       = res_int_q;

  `MPE_ASSERT(a_back_cnt, cnt_q <= CNT_W'(MAX_ITERATIONS), "iteration count above limit")
  `MPE_ASSERT(a_back_rem, rem_q < ACC_W'(MAX_ITERATIONS), "intensity remainder out of range")
  `MPE_ASSERT_IMPL(a_back_start, pt_take, ##1 (state_q == B_MUL && cnt_q == '0), "bad start")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the mandelbrot pixel engine: a directed table of
// corner pixels and grid sizes, then random phases under several grid sizes
// with random idling on both channels; every result is checked against the
// table's known outcome or an escape-time predictor in Q4.28 fixed point
// ----------------------------------------------------------------------------
module testbench;
  import mpe_pkg::*;

  localparam int unsigned ITER_LIMIT       = 1000;
  localparam int unsigned WATCHDOG_LIMIT   = 20000;
  localparam int unsigned RESULT_HOLD      = 4000;
  localparam int unsigned SETTLE_CYCLES    = 200;
  localparam int unsigned PHASES           = 8;
  localparam int unsigned PIXELS_PER_PHASE = 75;
  localparam int unsigned REPORT_CAP       = 50;
  localparam grid_t       GRID_AT_RESET    = 13'd1024;

  // Q4.28 view of the set
  localparam int unsigned FIX_FRAC    = 28;
  localparam longint      WIN_RE_LO   = -64'sd536870912;
  localparam longint      WIN_RE_SPAN = 64'sd663035576;
  localparam longint      WIN_IM_LO   = -64'sd300647711;
  localparam longint      WIN_IM_SPAN = 64'sd601295421;
  localparam longint      FIX_HI      = 64'sd2147483647;
  localparam longint      FIX_LO      = -64'sd2147483648;
  localparam longint      RADIUS_SQ   = 64'sd1073741824;

  typedef struct packed {
    count_t  iteration_count;
    intens_t intensity;
  } escape_t;

  typedef enum logic {STEP_PIXEL, STEP_GRID} step_kind_e;

  typedef struct packed {
    step_kind_e kind;
    grid_t      grid;
    coord_t     row;
    coord_t     col;
    logic       known;
    count_t     count;
    intens_t    level;
  } step_t;

  localparam int STEP_COUNT = 26;

  // known outcomes only where c lands far outside the set or next to the origin
  step_t directed_steps [STEP_COUNT] = '{
    '{STEP_PIXEL, 13'd0,    12'd0,    12'd0,    1'b1, 10'd1,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd4095, 12'd4095, 1'b1, 10'd1,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd512,  12'd829,  1'b1, 10'd1000, 8'd255},
    '{STEP_PIXEL, 13'd0,    12'd512,  12'd0,    1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd4095, 12'd0,    1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd0,    12'd4095, 1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd700,  12'd600,  1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd300,  12'd200,  1'b0, 10'd0,    8'd0},
    // zero grid behaves as a grid of one
    '{STEP_GRID,  13'd0,    12'd0,    12'd0,    1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd0,    12'd0,    1'b1, 10'd1,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd1,    12'd1,    1'b0, 10'd0,    8'd0},
    // far beyond the grid: both parts of c saturate
    '{STEP_PIXEL, 13'd0,    12'd4095, 12'd4095, 1'b1, 10'd1,    8'd0},
    '{STEP_GRID,  13'd8191, 12'd0,    12'd0,    1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd4095, 12'd4095, 1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd0,    12'd0,    1'b1, 10'd1,    8'd0},
    '{STEP_GRID,  13'd4096, 12'd0,    12'd0,    1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd2048, 12'd3317, 1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd2730, 12'd1365, 1'b0, 10'd0,    8'd0},
    '{STEP_GRID,  13'd1,    12'd0,    12'd0,    1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd0,    12'd1,    1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd1,    12'd0,    1'b0, 10'd0,    8'd0},
    '{STEP_GRID,  13'd2730, 12'd0,    12'd0,    1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd1365, 12'd2730, 1'b0, 10'd0,    8'd0},
    '{STEP_GRID,  13'd5461, 12'd0,    12'd0,    1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd2730, 12'd1365, 1'b0, 10'd0,    8'd0},
    '{STEP_PIXEL, 13'd0,    12'd4095, 12'd2048, 1'b0, 10'd0,    8'd0}
  };

  logic  clk_i;
  logic  rst_ni;
  logic  cfg_we_i;
  grid_t cfg_wdata_i;

  mpe_pix_if pix ();
  mpe_res_if res ();

  mandelbrot_pixel_engine #(
    .MAX_ITERATIONS (ITER_LIMIT),
    .COORD_BITS     (COORD_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix),
    .res_o       (res)
  );

  escape_t     expected_pixels [$];
  grid_t       grid_setting = GRID_AT_RESET;
  bit          steady_phase = 1'b0;
  bit          hold_results = 1'b0;
  int unsigned mismatches      = 0;
  int unsigned pixels_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned grid_writes     = 0;
  int unsigned bounded_pixels  = 0;
  int unsigned quick_escapes   = 0;
  int unsigned long_holds      = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clamp_fix(longint v);
    if (v > FIX_HI) return FIX_HI;
    if (v < FIX_LO) return FIX_LO;
    return v;
  endfunction

  function automatic escape_t predict_escape(coord_t row, coord_t col, grid_t grid);
    longint      side, c_re, c_im, z_re, z_im, re_sq, im_sq, twice_ri;
    int unsigned count;
    escape_t     esc;
    side  = (grid == '0) ? 64'sd1 : longint'(grid);
    c_re  = clamp_fix(WIN_RE_LO + (longint'(col) * WIN_RE_SPAN) / side);
    c_im  = clamp_fix(WIN_IM_LO + (longint'(row) * WIN_IM_SPAN) / side);
    z_re  = 0;
    z_im  = 0;
    count = 0;
    forever begin
      re_sq = (z_re * z_re) >>> FIX_FRAC;
      im_sq = (z_im * z_im) >>> FIX_FRAC;
      if (re_sq + im_sq > RADIUS_SQ || count >= ITER_LIMIT) break;
      // arithmetic shift floors the doubled cross term
      twice_ri = (z_re * z_im) >>> (FIX_FRAC - 1);
      z_re     = clamp_fix(re_sq - im_sq + c_re);
      z_im     = clamp_fix(twice_ri + c_im);
      count++;
    end
    esc.iteration_count = count_t'(count);
    esc.intensity       = intens_t'((255 * count) / ITER_LIMIT);
    return esc;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_length();
    int unsigned pick;
    if (steady_phase) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 16);
    return $urandom_range(30, 200);
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < REPORT_CAP) $display("mismatch: %s", what);
    mismatches++;
  endtask

  task automatic check_result();
    escape_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("result with nothing outstanding: count %0d intensity %0d",
                                res.iteration_count, res.intensity));
    end else begin
      want = expected_pixels.pop_front();
      results_checked++;
      if (res.iteration_count !== want.iteration_count)
        report_mismatch($sformatf("result %0d: iteration_count %0d, expected %0d",
                                  results_checked, res.iteration_count,
                                  want.iteration_count));
      if (res.intensity !== want.intensity)
        report_mismatch($sformatf("result %0d: intensity %0d, expected %0d",
                                  results_checked, res.intensity, want.intensity));
    end
  endtask

  task automatic send_pixel(coord_t row, coord_t col, escape_t want);
    int unsigned gap;
    pix.valid        <= 1'b1;
    pix.pixel_row    <= row;
    pix.pixel_column <= col;
    @(posedge clk_i);
    while (pix.ready !== 1'b1) @(posedge clk_i);
    expected_pixels.push_back(want);
    pixels_sent++;
    if (want.iteration_count == ITER_LIMIT) bounded_pixels++;
    if (want.iteration_count == 1) quick_escapes++;
    gap = gap_length();
    if (gap != 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_pipeline();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_grid(grid_t value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    grid_setting = value;
    grid_writes++;
  endtask

  initial begin : result_side
    int unsigned stall_left;
    stall_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res.valid === 1'b1 && res.ready === 1'b1) check_result();
      if (hold_results) begin
        hold_results = 1'b0;
        stall_left   = RESULT_HOLD;
        long_holds++;
      end
      if (stall_left != 0) begin
        res.ready <= 1'b0;
        stall_left--;
      end else begin
        res.ready  <= 1'b1;
        stall_left = gap_length();
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((pix.valid === 1'b1 && pix.ready === 1'b1) ||
          (res.valid === 1'b1 && res.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned side;
    int unsigned top;
    coord_t      row_pick;
    coord_t      col_pick;
    escape_t     want;

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    pix.valid        <= 1'b0;
    pix.pixel_row    <= '0;
    pix.pixel_column <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_GRID) begin
        drain_pipeline();
        write_grid(directed_steps[i].grid);
      end else begin
        if (directed_steps[i].known) begin
          want.iteration_count = directed_steps[i].count;
          want.intensity       = directed_steps[i].level;
        end else begin
          want = predict_escape(directed_steps[i].row, directed_steps[i].col, grid_setting);
        end
        send_pixel(directed_steps[i].row, directed_steps[i].col, want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipeline();
      case (phase)
        0:       write_grid(GRID_AT_RESET);
        1:       write_grid('0);
        2:       write_grid(13'd8191);
        3:       write_grid(13'd4096);
        4:       write_grid(13'd1);
        5:       write_grid(grid_t'($urandom_range(2, 63)));
        6:       write_grid(grid_t'($urandom_range(64, 4095)));
        default: write_grid(grid_t'($urandom_range(1, 8191)));
      endcase
      steady_phase = (phase == 2);
      side = (grid_setting == '0) ? 1 : grid_setting;
      top  = (side > 4096) ? 4095 : side - 1;
      for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
        // long result back-pressure while pixels keep coming
        if (phase == 3 && k == 5) hold_results = 1'b1;
        if (phase == 6 && k == 40) drain_pipeline();
        if ($urandom_range(0, 99) < 85) begin
          row_pick = coord_t'($urandom_range(0, top));
          col_pick = coord_t'($urandom_range(0, top));
        end else begin
          row_pick = coord_t'($urandom());
          col_pick = coord_t'($urandom());
        end
        send_pixel(row_pick, col_pick, predict_escape(row_pick, col_pick, grid_setting));
      end
    end

    drain_pipeline();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d pixels, %0d grid writes, %0d at the limit, %0d escaping at once",
             pixels_sent, grid_writes, bounded_pixels, quick_escapes);
    $display("%0d results checked, %0d long result hold-offs, %0d mismatches",
             results_checked, long_holds, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mpe_pkg.sv
rtl/mpe_if.sv
rtl/mpe_front.sv
rtl/mpe_queue.sv
rtl/mpe_back.sv
rtl/mandelbrot_pixel_engine.sv
tb/testbench.sv
